// ===== rtl/row_extent_tracker_smoothed_core_macros.svh =====
// assertion macros shared by the checker files of the row extent tracker
// depends on clk and arst_n being visible at the point of use
`ifndef ROW_EXTENT_TRACKER_SMOOTHED_CORE_MACROS_SVH
`define ROW_EXTENT_TRACKER_SMOOTHED_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define REXT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rext assertion failed");

// next-cycle implication, disabled during reset
`define REXT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rext assertion failed");

`endif

// ===== rtl/rext_pkg.sv =====
// shared types, constants and helper functions of the row extent tracker
// no dependencies
package rext_pkg;

	localparam int COORD_W    = 12;
	localparam int WIDTH_W    = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	typedef logic [COORD_W-1:0] coord_t;

	// register map of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH = 2'd0,
		CFG_JUMP_LIMIT  = 2'd1,
		CFG_SMOOTH_THR  = 2'd2
	} cfg_idx_t;

	// reset values of the registers
	localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RST = 13'd640;
	localparam coord_t             JUMP_LIMIT_RST  = 12'd60;
	localparam coord_t             SMOOTH_THR_RST  = 12'd30;

	// width clamp limits
	localparam int WIDTH_CAP_I = (MAX_WIDTH > 4096) ? 4096 : ((MAX_WIDTH < 3) ? 3 : MAX_WIDTH);
	localparam logic [WIDTH_W-1:0] WIDTH_CAP = WIDTH_W'(WIDTH_CAP_I);
	localparam logic [WIDTH_W-1:0] WIDTH_MIN = 13'd3;
	localparam int LAST_COL_RST_I =
		((640 > WIDTH_CAP_I) ? WIDTH_CAP_I : 640) - 1;
	localparam coord_t LAST_COL_RST = COORD_W'(LAST_COL_RST_I);

	// row counter saturation point
	localparam int ROW_CAP_I = ((MAX_HEIGHT - 1) > 4095) ? 4095 : (MAX_HEIGHT - 1);
	localparam coord_t ROW_CAP   = COORD_W'(ROW_CAP_I);
	localparam coord_t COORD_MAX = '1;

	// blend weight 0.02 in 16 fractional bits
	localparam logic [10:0] W_SMALL    = 11'd1311;
	localparam int          FRAC_BITS  = 16;
	// reciprocal of three, exact floor for all 12-bit inputs
	localparam logic [11:0] RECIP3     = 12'd2731;
	localparam int          RECIP3_SH  = 13;

	// active configuration as seen by the datapath
	typedef struct packed {
		coord_t last_col;
		coord_t jump_limit;
		coord_t smooth_thr;
	} cfg_t;

	// extent of the row closed by the current pixel
	typedef struct packed {
		logic   row_done;
		logic   frame_done;
		coord_t row_index;
		coord_t left;
		coord_t right;
	} row_sum_t;

	// filtered edge pair
	typedef struct packed {
		logic   emit;
		coord_t left;
		coord_t right;
	} edge_res_t;

	function automatic coord_t div3(input coord_t x);
		logic [2*COORD_W-1:0] prod;
		prod = x * RECIP3;
		return COORD_W'(prod >> RECIP3_SH);
	endfunction

	function automatic coord_t absdiff(input coord_t a, input coord_t b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

// ===== rtl/row_extent_tracker_smoothed_core.sv =====
// a result is loaded into the result register when the pixel that closes its row leaves the input register
// throughput: one pixel per cycle unless a result waits with out_ready low; the state updates behind the input register
// the output register is taken and refilled in the same cycle, so pixels flow while out_ready is high
// reset: asynchronous, clears tracking state, drops pending transactions, restores
// image_width 640, jump_limit 60, smooth_threshold 30; no clearing pass
module row_extent_tracker_smoothed_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              pixel_on,
	input  logic                              row_end,
	input  logic                              frame_end,
	output logic                              out_valid,
	input  logic                              out_ready,
	output rext_pkg::coord_t                  row_index,
	output rext_pkg::coord_t                  left_x,
	output rext_pkg::coord_t                  right_x,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rext_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rext_pkg::WIDTH_W-1:0]      cfg_data
);

	logic                valid_s1;
	logic                pixel_on_s1;
	logic                row_end_s1;
	logic                frame_end_s1;
	logic                advance;
	logic                out_valid_q;
	rext_pkg::coord_t    row_index_q;
	rext_pkg::coord_t    left_x_q;
	rext_pkg::coord_t    right_x_q;
	rext_pkg::cfg_t      cfg;
	rext_pkg::row_sum_t  row_sum;
	rext_pkg::edge_res_t res;

	// handshake control
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	rext_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pixel_on_s1  <= pixel_on;
			row_end_s1   <= row_end;
			frame_end_s1 <= frame_end;
		end
	end

	rext_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.pixel_on  (pixel_on_s1),
		.row_end   (row_end_s1),
		.frame_end (frame_end_s1),
		.last_col  (cfg.last_col),
		.row_sum   (row_sum)
	);

	rext_smooth u_smooth (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.row_sum (row_sum),
		.cfg     (cfg),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) begin
			row_index_q <= row_sum.row_index;
			left_x_q    <= res.left;
			right_x_q   <= res.right;
		end
	end

	assign out_valid = out_valid_q;
	assign row_index = row_index_q;
	assign left_x    = left_x_q;
	assign right_x   = right_x_q;

endmodule

// ===== rtl/rext_cfg.sv =====
// configuration registers and effective width clamp
// depends on rext_pkg
module rext_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [rext_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [rext_pkg::WIDTH_W-1:0]      wr_data,
	output rext_pkg::cfg_t                    cfg
);

	logic [rext_pkg::WIDTH_W-1:0] image_width_q;
	rext_pkg::coord_t             jump_limit_q;
	rext_pkg::coord_t             smooth_thr_q;
	rext_pkg::coord_t             last_col;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= rext_pkg::IMAGE_WIDTH_RST;
			jump_limit_q  <= rext_pkg::JUMP_LIMIT_RST;
			smooth_thr_q  <= rext_pkg::SMOOTH_THR_RST;
		end else if (wr_en) begin
			case (rext_pkg::cfg_idx_t'(wr_index))
				rext_pkg::CFG_IMAGE_WIDTH: image_width_q <= wr_data;
				rext_pkg::CFG_JUMP_LIMIT:  jump_limit_q  <= wr_data[rext_pkg::COORD_W-1:0];
				rext_pkg::CFG_SMOOTH_THR:  smooth_thr_q  <= wr_data[rext_pkg::COORD_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp width into the supported range and take the last column
	always_comb begin
		if (image_width_q > rext_pkg::WIDTH_CAP)
			last_col = rext_pkg::COORD_W'(rext_pkg::WIDTH_CAP - 13'd1);
		else if (image_width_q < rext_pkg::WIDTH_MIN)
			last_col = rext_pkg::COORD_W'(rext_pkg::WIDTH_MIN - 13'd1);
		else
			last_col = rext_pkg::COORD_W'(image_width_q - 13'd1);
	end

	assign cfg.last_col   = last_col;
	assign cfg.jump_limit = jump_limit_q;
	assign cfg.smooth_thr = smooth_thr_q;

endmodule

// ===== rtl/rext_track.sv =====
// column and row counters with the running left and right extent of a row
// depends on rext_pkg
module rext_track (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                pixel_on,
	input  logic                row_end,
	input  logic                frame_end,
	input  rext_pkg::coord_t    last_col,
	output rext_pkg::row_sum_t  row_sum
);

	rext_pkg::coord_t col_q;
	rext_pkg::coord_t row_q;
	rext_pkg::coord_t run_left_q;
	rext_pkg::coord_t run_right_q;
	rext_pkg::coord_t left_now;
	rext_pkg::coord_t right_now;
	logic             in_row;

	// extent including the current pixel
	always_comb begin
		in_row    = pixel_on && (col_q <= last_col);
		left_now  = (in_row && (col_q < run_left_q)) ? col_q : run_left_q;
		right_now = (in_row && (col_q > run_right_q)) ? col_q : run_right_q;
	end

	assign row_sum.row_done   = row_end;
	assign row_sum.frame_done = frame_end;
	assign row_sum.row_index  = row_q;
	assign row_sum.left       = left_now;
	assign row_sum.right      = right_now;

	// counter and extent update per pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			run_left_q  <= rext_pkg::LAST_COL_RST;
			run_right_q <= '0;
		end else if (step) begin
			if (frame_end) begin
				col_q       <= '0;
				row_q       <= '0;
				run_left_q  <= last_col;
				run_right_q <= '0;
			end else if (row_end) begin
				col_q       <= '0;
				run_left_q  <= last_col;
				run_right_q <= '0;
				if (row_q < rext_pkg::ROW_CAP)
					row_q <= row_q + 12'd1;
			end else begin
				run_left_q  <= left_now;
				run_right_q <= right_now;
				if (col_q < rext_pkg::COORD_MAX)
					col_q <= col_q + 12'd1;
			end
		end
	end

endmodule

// ===== rtl/rext_smooth.sv =====
// row validity, jump rejection and edge blending against the last emitted pair
// depends on rext_pkg
module rext_smooth (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  rext_pkg::row_sum_t   row_sum,
	input  rext_pkg::cfg_t       cfg,
	output rext_pkg::edge_res_t  res
);

	rext_pkg::coord_t prev_left_q;
	rext_pkg::coord_t prev_right_q;
	logic             have_prev_q;

	rext_pkg::coord_t dl;
	rext_pkg::coord_t dr;
	rext_pkg::coord_t l_div;
	rext_pkg::coord_t p_div;
	rext_pkg::coord_t left_blend;
	rext_pkg::coord_t right_big;
	logic [22:0]      right_prod;
	logic [23:0]      right_ceil;
	rext_pkg::coord_t right_blend;
	logic             row_valid;
	logic             emit;

	// jumps from the last emitted pair
	assign dl = rext_pkg::absdiff(row_sum.left, prev_left_q);
	assign dr = rext_pkg::absdiff(row_sum.right, prev_right_q);

	// left blend in thirds
	always_comb begin
		l_div = rext_pkg::div3(row_sum.left);
		p_div = rext_pkg::div3(prev_left_q);
		if (row_sum.left > prev_left_q)
			left_blend = l_div + {p_div[10:0], 1'b0};
		else
			left_blend = {l_div[10:0], 1'b0} + p_div;
	end

	// right blend: larger edge minus the rounded-up small-weight share of the jump
	always_comb begin
		right_big   = (row_sum.right > prev_right_q) ? row_sum.right : prev_right_q;
		right_prod  = dr * rext_pkg::W_SMALL;
		right_ceil  = {1'b0, right_prod} + 24'hFFFF;
		right_blend = right_big - rext_pkg::COORD_W'(right_ceil >> rext_pkg::FRAC_BITS);
	end

	// accept or drop the row
	always_comb begin
		row_valid = (row_sum.left != cfg.last_col) && (row_sum.right > 12'd1)
			&& (row_sum.left != row_sum.right);
		emit      = row_sum.row_done && row_valid
			&& (!have_prev_q || (dl < cfg.jump_limit));
		res.emit  = emit;
		res.left  = row_sum.left;
		res.right = row_sum.right;
		if (have_prev_q && (dl > cfg.smooth_thr))
			res.left = left_blend;
		if (have_prev_q && (dr > cfg.smooth_thr))
			res.right = right_blend;
	end

	// reference pair update, frame end clears after a possible emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_left_q  <= '0;
			prev_right_q <= '0;
			have_prev_q  <= 1'b0;
		end else if (step) begin
			if (row_sum.frame_done) begin
				prev_left_q  <= '0;
				prev_right_q <= '0;
				have_prev_q  <= 1'b0;
			end else if (emit) begin
				prev_left_q  <= res.left;
				prev_right_q <= res.right;
				have_prev_q  <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/rext_checker.sv =====
// port-level checks of the row extent tracker, attached by bind
// depends on rext_pkg and row_extent_tracker_smoothed_core_macros.svh
`include "row_extent_tracker_smoothed_core_macros.svh"

module rext_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              row_end,
	input logic                              out_valid,
	input logic                              out_ready,
	input rext_pkg::coord_t                  row_index,
	input rext_pkg::coord_t                  left_x,
	input rext_pkg::coord_t                  right_x,
	input logic                              cfg_valid,
	input logic                              cfg_ready
);

	// a stalled result transaction holds
	`REXT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(row_index) && $stable(left_x) && $stable(right_x))

	// with no result pending the input side never stalls
	`REXT_ASSERT_IMPL(a_in_free, !out_valid, in_ready)

	// a new result comes only from an accepted row end that has passed the input and result registers
	`REXT_ASSERT_IMPL(a_out_src, $rose(out_valid), $past(in_valid && in_ready && row_end, 2))

	// register writes are never stalled
	`REXT_ASSERT_IMPL(a_cfg_open, cfg_valid, cfg_ready)

endmodule

bind row_extent_tracker_smoothed_core rext_checker u_rext_checker (.*);

// ===== sim/row_extent_tracker_smoothed_core_checker.sv =====
`timescale 1ns / 1ps
// checker for the row extent tracker: watches the pixel, register and result channels,
// predicts each accepted edge pair and compares it field by field; depends on rext_pkg
module row_extent_tracker_smoothed_core_checker (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	input  logic                                     in_ready,
	input  logic                                     pixel_on,
	input  logic                                     row_end,
	input  logic                                     frame_end,
	input  logic                                     out_valid,
	input  logic                                     out_ready,
	input  rext_pkg::coord_t                         row_index,
	input  rext_pkg::coord_t                         left_x,
	input  rext_pkg::coord_t                         right_x,
	input  logic                                     cfg_valid,
	input  logic                                     cfg_ready,
	input  logic [rext_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [rext_pkg::WIDTH_W-1:0]             cfg_data,
	output int                                       mismatches,
	output int                                       edges_due
);

	// right edge blend weights, 16 fractional bits
	localparam logic [15:0] BLEND_FAR  = 16'd1311;
	localparam logic [15:0] BLEND_NEAR = 16'd64225;

	typedef struct packed {
		rext_pkg::coord_t row;
		rext_pkg::coord_t lft;
		rext_pkg::coord_t rgt;
	} edge_pair_t;

	edge_pair_t                   edge_q[$];
	logic [rext_pkg::WIDTH_W-1:0] width_reg;
	rext_pkg::coord_t             jump_reg;
	rext_pkg::coord_t             smooth_reg;
	rext_pkg::coord_t             col_cnt;
	rext_pkg::coord_t             row_cnt;
	rext_pkg::coord_t             span_l;
	rext_pkg::coord_t             span_r;
	rext_pkg::coord_t             ref_l;
	rext_pkg::coord_t             ref_r;
	logic                         have_ref;
	int                           err_cnt;

	// last usable column for a width register value
	function automatic rext_pkg::coord_t last_column(input logic [rext_pkg::WIDTH_W-1:0] w);
		logic [rext_pkg::WIDTH_W-1:0] c;
		c = w;
		if (c > rext_pkg::WIDTH_CAP) c = rext_pkg::WIDTH_CAP;
		if (c < rext_pkg::WIDTH_MIN) c = rext_pkg::WIDTH_MIN;
		return rext_pkg::coord_t'(c - 1'b1);
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		err_cnt++;
	endtask

	// frame end or reset wipes all tracking state
	task automatic clear_frame();
		col_cnt  = '0;
		row_cnt  = '0;
		span_l   = last_column(width_reg);
		span_r   = '0;
		ref_l    = '0;
		ref_r    = '0;
		have_ref = 1'b0;
	endtask

	// advance the tracker by one pixel, queue the edge pair it closes, if any
	task automatic track_pixel(input logic on, input logic rend, input logic fend);
		rext_pkg::coord_t lc;
		rext_pkg::coord_t l;
		rext_pkg::coord_t r;
		rext_pkg::coord_t dl;
		rext_pkg::coord_t dr;
		logic [31:0]      acc;
		logic             emit;
		edge_pair_t       pair;
		lc = last_column(width_reg);
		if (on && col_cnt <= lc) begin
			if (col_cnt > span_r) span_r = col_cnt;
			if (col_cnt < span_l) span_l = col_cnt;
		end
		if (col_cnt < rext_pkg::COORD_MAX) col_cnt = col_cnt + 1'b1;

		if (rend) begin
			l    = span_l;
			r    = span_r;
			emit = 1'b0;
			if (l != lc && r > 1 && l != r) begin
				dl = (l > ref_l) ? l - ref_l : ref_l - l;
				dr = (r > ref_r) ? r - ref_r : ref_r - r;
				if (!have_ref) begin
					emit = 1'b1;
				end else if (dl < jump_reg) begin
					// left edge: blend in thirds toward the reference
					if (dl > smooth_reg) begin
						if (l > ref_l) l = rext_pkg::coord_t'(l / 3 + (ref_l / 3) * 2);
						else l = rext_pkg::coord_t'((l / 3) * 2 + ref_l / 3);
					end
					// right edge: fixed point blend, truncated
					if (dr > smooth_reg) begin
						if (r < ref_r) acc = 32'(r) * 32'(BLEND_FAR) + 32'(ref_r) * 32'(BLEND_NEAR);
						else acc = 32'(r) * 32'(BLEND_NEAR) + 32'(ref_r) * 32'(BLEND_FAR);
						r = rext_pkg::coord_t'(acc >> rext_pkg::FRAC_BITS);
					end
					emit = 1'b1;
				end
			end
			if (emit) begin
				pair.row = row_cnt;
				pair.lft = l;
				pair.rgt = r;
				edge_q.insert(edge_q.size(), pair);
				ref_l    = l;
				ref_r    = r;
				have_ref = 1'b1;
			end
			if (row_cnt < rext_pkg::ROW_CAP) row_cnt = row_cnt + 1'b1;
			col_cnt = '0;
			span_l  = lc;
			span_r  = '0;
		end

		if (fend) clear_frame();
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		edge_pair_t want;
		if (!arst_n) begin
			edge_q.delete();
			width_reg  = rext_pkg::IMAGE_WIDTH_RST;
			jump_reg   = rext_pkg::JUMP_LIMIT_RST;
			smooth_reg = rext_pkg::SMOOTH_THR_RST;
			clear_frame();
			err_cnt    = 0;
			mismatches <= 0;
			edges_due  <= 0;
		end else begin
			// result transaction against the oldest expectation
			if (out_valid && out_ready) begin
				if (edge_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected result row %0d left %0d right %0d",
						row_index, left_x, right_x));
				end else begin
					want = edge_q.pop_front();
					if (row_index !== want.row)
						flag_mismatch($sformatf("row_index got %0d expected %0d",
							row_index, want.row));
					if (left_x !== want.lft)
						flag_mismatch($sformatf("left_x got %0d expected %0d (row %0d)",
							left_x, want.lft, want.row));
					if (right_x !== want.rgt)
						flag_mismatch($sformatf("right_x got %0d expected %0d (row %0d)",
							right_x, want.rgt, want.row));
				end
			end

			// register write transaction
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rext_pkg::CFG_IMAGE_WIDTH: width_reg  = cfg_data;
					rext_pkg::CFG_JUMP_LIMIT:  jump_reg   = cfg_data[rext_pkg::COORD_W-1:0];
					rext_pkg::CFG_SMOOTH_THR:  smooth_reg = cfg_data[rext_pkg::COORD_W-1:0];
					default: ;
				endcase
			end

			// pixel transaction
			if (in_valid && in_ready) track_pixel(pixel_on, row_end, frame_end);

			mismatches <= err_cnt;
			edges_due  <= edge_q.size();
		end
	end

endmodule

// ===== sim/row_extent_tracker_smoothed_core_test.sv =====
`timescale 1ns / 1ps
// testbench top for the row extent tracker: clock, reset, pixel and register stimulus,
// result sink and verdict; depends on rext_pkg, the core and its checker
module row_extent_tracker_smoothed_core_test;

	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_PIXELS  = 70;
	localparam logic [rext_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           pixel_on  = 1'b0;
	logic                           row_end   = 1'b0;
	logic                           frame_end = 1'b0;
	logic                           out_ready = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic [rext_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [rext_pkg::WIDTH_W-1:0]   cfg_data  = '0;
	logic                           in_ready;
	logic                           out_valid;
	logic                           cfg_ready;
	rext_pkg::coord_t               row_index;
	rext_pkg::coord_t               left_x;
	rext_pkg::coord_t               right_x;
	int                             mismatches;
	int                             edges_due;

	bit burst       = 1'b0;
	bit hold_req    = 1'b0;
	int pixels_sent = 0;
	int width_now   = 640;
	int jump_now    = 60;
	int cur_l       = 2;
	int cur_r       = 20;

	always #2 clk = ~clk;

	row_extent_tracker_smoothed_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_on  (pixel_on),
		.row_end   (row_end),
		.frame_end (frame_end),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.row_index (row_index),
		.left_x    (left_x),
		.right_x   (right_x),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	row_extent_tracker_smoothed_core_checker edge_watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_on   (pixel_on),
		.row_end    (row_end),
		.frame_end  (frame_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.row_index  (row_index),
		.left_x     (left_x),
		.right_x    (right_x),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.edges_due  (edges_due)
	);

	function automatic int idle_draw();
		return burst ? 0 : $urandom_range(0, 17);
	endfunction

	// width as the block clamps it
	function automatic int eff_width(input int w);
		if (w > rext_pkg::WIDTH_CAP_I) return rext_pkg::WIDTH_CAP_I;
		if (w < 3) return 3;
		return w;
	endfunction

	function automatic int bound(input int v, input int w);
		if (v < 0) return 0;
		if (v > w - 1) return w - 1;
		return v;
	endfunction

	// one pixel transaction, valid held until accepted
	task automatic send_pixel(input logic on, input logic rend, input logic fend);
		int gap;
		gap = idle_draw();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		pixel_on  <= on;
		row_end   <= rend;
		frame_end <= fend;
		do @(posedge clk); while (!in_ready);
		pixels_sent++;
	endtask

	// a row with set pixels at lft and rgt, filled between, noise anywhere
	task automatic send_row(input int len, input int lft, input int rgt, input int fill,
			input int noise, input bit closes, input bit ends_frame);
		int   c;
		logic on;
		bit   last;
		for (c = 0; c < len; c++) begin
			last = (c == len - 1);
			on = (c == lft) || (c == rgt) ||
				(c > lft && c < rgt && $urandom_range(0, 99) < fill) ||
				($urandom_range(0, 99) < noise);
			send_pixel(on, last && closes, last && ends_frame);
		end
	endtask

	task automatic write_reg(input logic [rext_pkg::CFG_IDX_W-1:0] idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= rext_pkg::WIDTH_W'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input int w, input int j, input int s);
		write_reg(rext_pkg::CFG_IMAGE_WIDTH, w);
		write_reg(rext_pkg::CFG_JUMP_LIMIT, j);
		write_reg(rext_pkg::CFG_SMOOTH_THR, s);
		width_now = w;
		jump_now  = j;
	endtask

	// stop offering pixels until every expected edge pair is out, then let the pipe empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (edges_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly drifting well-formed rows, with noise, empty and frame-ending rows mixed in
	task automatic random_rows(input int budget);
		int w;
		int span;
		int start;
		int kind;
		int d;
		int lft;
		int rgt;
		w     = eff_width(width_now);
		span  = (jump_now + 8 < w) ? jump_now + 8 : w;
		start = pixels_sent;
		while (pixels_sent - start < budget) begin
			d     = $urandom_range(0, 2 * span);
			cur_l = bound(cur_l + d - span, w);
			d     = $urandom_range(0, 2 * span);
			cur_r = bound(cur_r + d - span, w);
			lft   = (cur_l < cur_r) ? cur_l : cur_r;
			rgt   = (cur_l < cur_r) ? cur_r : cur_l;
			kind  = $urandom_range(0, 99);
			if (kind < 70) send_row(w, lft, rgt, $urandom_range(0, 100), 0, 1'b1, 1'b0);
			else if (kind < 80)
				send_row($urandom_range(1, w + 3), -1, -1, 0, $urandom_range(5, 40), 1'b1, 1'b0);
			else if (kind < 85) send_row(w, -1, -1, 0, 0, 1'b1, 1'b0);
			else if (kind < 92) send_row(w, lft, rgt, 50, 0, 1'b1, 1'b1);
			else send_row($urandom_range(1, w), lft, rgt, 50, 5, 1'b0, 1'b1);
		end
	endtask

	// result sink: random stalls, one long hold-off on request
	initial begin : result_sink
		int stall;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				stall    = HOLD_CYCLES;
			end else begin
				stall = idle_draw();
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : stimulus
		int phase;
		int k;
		int w;
		int j;
		int s;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// power-up settings: one full-width raw row
		burst = 1'b1;
		send_row(640, 100, 500, 50, 0, 1'b1, 1'b0);
		burst = 1'b0;
		settle();

		// narrower rows under the reset jump and smoothing limits:
		// a left jump of exactly 60 is dropped, then a blended pair, then a near one
		write_reg(rext_pkg::CFG_IMAGE_WIDTH, 100);
		width_now = 100;
		burst = 1'b1;
		send_row(100, 40, 90, 50, 0, 1'b1, 1'b0);
		send_row(100, 55, 90, 50, 0, 1'b1, 1'b0);
		send_row(100, 80, 95, 50, 0, 1'b1, 1'b1);
		burst = 1'b0;
		settle();

		// directed: partial frame, column zero only, raw first row, overlong row closing the frame
		set_config(8, 3, 1);
		write_reg(CFG_UNMAPPED, 8191);
		send_row(4, 0, 3, 100, 0, 1'b0, 1'b1);
		send_row(8, 0, 0, 0, 0, 1'b1, 1'b0);
		send_row(8, 2, 7, 0, 0, 1'b1, 1'b0);
		send_row(10, 4, 9, 100, 0, 1'b1, 1'b1);
		settle();

		// random phases over a spread of settings
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 5))
				0: w = $urandom_range(0, 2);
				1: w = $urandom_range(49, 200);
				default: w = $urandom_range(3, 48);
			endcase
			case ($urandom_range(0, 5))
				0: j = 0;
				1: j = 1;
				2: j = 4095;
				default: j = $urandom_range(2, 80);
			endcase
			case ($urandom_range(0, 4))
				0: s = 0;
				1: s = 4095;
				default: s = $urandom_range(1, 40);
			endcase
			set_config(w, j, s);
			if (phase == 3) write_reg(CFG_UNMAPPED, $urandom_range(0, 8191));
			burst = ($urandom_range(0, 3) == 0);
			random_rows(PHASE_PIXELS);
			burst = 1'b0;
			settle();
		end

		// back-pressure: the sink holds off while short rows keep coming
		set_config(4, 4095, 0);
		burst    = 1'b1;
		hold_req = 1'b1;
		for (k = 0; k < 40; k++)
			send_row(4, $urandom_range(0, 1), $urandom_range(2, 3), 100, 0, 1'b1, 1'b0);
		burst = 1'b0;
		settle();

		if (mismatches == 0 && edges_due == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// run limit
	initial begin : watchdog
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
